[rtl/core/lshb_pkg.sv]
`timescale 1ns / 1ps
package lshb_pkg;
	localparam int MAX_BINS_DEF   = 64;
	localparam int COUNT_BITS_DEF = 32;
	localparam int SAMPLE_W = 16;
	localparam int NBINS_W  = 7;
	localparam int WIDTH_W  = 11;
	localparam int ROW_W    = 6;
	localparam int LOG_W    = 23;
	localparam int DIV_W    = 34;

	typedef enum logic [1:0] {
		REG_DATA_MIN  = 2'd0,
		REG_DATA_MAX  = 2'd1,
		REG_NUM_BINS  = 2'd2,
		REG_BAR_WIDTH = 2'd3
	} reg_idx_t;

	function automatic logic [16:0] log_tab(input logic [4:0] i);
		logic [16:0] r;
		case (i)
			5'd0:  r = 17'd0;
			5'd1:  r = 17'd5732;
			5'd2:  r = 17'd11136;
			5'd3:  r = 17'd16248;
			5'd4:  r = 17'd21098;
			5'd5:  r = 17'd25711;
			5'd6:  r = 17'd30109;
			5'd7:  r = 17'd34312;
			5'd8:  r = 17'd38336;
			5'd9:  r = 17'd42196;
			5'd10: r = 17'd45904;
			5'd11: r = 17'd49472;
			5'd12: r = 17'd52911;
			5'd13: r = 17'd56229;
			5'd14: r = 17'd59434;
			5'd15: r = 17'd62534;
			5'd16: r = 17'd65536;
			default: r = 17'd0;
		endcase
		return r;
	endfunction
endpackage

[rtl/core/lshb_divider.sv]
`timescale 1ns / 1ps
module lshb_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lshb_pkg::DIV_W-1:0] num,
	input  logic [lshb_pkg::DIV_W-1:0] den,
	output logic                      done,
	output logic [lshb_pkg::DIV_W-1:0] quo,
	output logic [lshb_pkg::DIV_W-1:0] rem
);
	localparam int W = lshb_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  d_q;
	logic [W:0]    r_q;
	logic [W:0]    trial;
	logic [W:0]    sh;

	assign sh    = {r_q[W-1:0], n_q[W-1]};
	assign trial = sh - {1'b0, d_q};
	assign quo   = n_q;
	assign rem   = r_q[W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial;
				n_q <= {n_q[W-2:0], 1'b1};
			end else begin
				r_q <= sh;
				n_q <= {n_q[W-2:0], 1'b0};
			end
		end
	end
endmodule

[rtl/core/lshb_log2.sv]
`timescale 1ns / 1ps
module lshb_log2 #(
	parameter int COUNT_BITS = lshb_pkg::COUNT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [COUNT_BITS-1:0]     n,
	output logic                      done,
	output logic [lshb_pkg::LOG_W-1:0] lg
);
	localparam int XW = (COUNT_BITS + 1 > 21) ? COUNT_BITS + 1 : 21;
	localparam int EW = $clog2(XW);

	logic [XW-1:0] x_q;
	logic [EW-1:0] e_q;
	logic [1:0]    ph_q;
	logic [4:0]    idx;
	logic [15:0]   f;
	logic [16:0]   lo;
	logic [16:0]   hi;
	logic [32:0]   prod;

	assign idx  = {1'b0, x_q[XW-2 -: 4]};
	assign f    = x_q[XW-6 -: 16];
	assign lo   = lshb_pkg::log_tab(idx);
	assign hi   = lshb_pkg::log_tab(idx + 5'd1);
	assign prod = (hi - lo) * f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				ph_q <= 2'd1;
			end else if (ph_q == 2'd1 && x_q[XW-1]) begin
				ph_q <= 2'd2;
			end else if (ph_q == 2'd2) begin
				ph_q <= 2'd0;
				done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= XW'(n) + XW'(1);
			e_q <= EW'(XW - 1);
		end else if (ph_q == 2'd1 && !x_q[XW-1]) begin
			x_q <= {x_q[XW-2:0], 1'b0};
			e_q <= e_q - 1'b1;
		end else if (ph_q == 2'd2) begin
			lg <= {(lshb_pkg::LOG_W - 16 - EW)'(0), e_q, 16'd0} + lshb_pkg::LOG_W'(lo)
				+ lshb_pkg::LOG_W'(prod[32:16]);
		end
	end
endmodule

[rtl/core/log_scaled_histogram_bars.sv]
`timescale 1ns / 1ps
// channel   | dir | signals                     | content
// s_axis    | in  | tvalid tready tdata tlast   | sample; tlast = last_sample
// m_axis    | out | tvalid tready tdata tlast   | row, white_count; tlast = last_row
// cfg       | in  | valid ready index data      | register writes
// Each sample runs a 34-step shift-subtract divide for the bin, then a read and write
// of the bin count; the next sample is accepted only after that write.
// After the last sample: one log of the peak, then per row a bin read,
// one log and one 34-step divide, plus output stall.
// Then a clearing pass over all MAX_BINS bins.
// Reset loads defaults and starts the clearing pass; no sample is taken meanwhile.
module log_scaled_histogram_bars #(
	parameter int MAX_BINS   = lshb_pkg::MAX_BINS_DEF,
	parameter int COUNT_BITS = lshb_pkg::COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [5:0] row, [16:6] white_count, zero fill
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int BW = $clog2(MAX_BINS);
	localparam int DW = lshb_pkg::DIV_W;
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	typedef enum logic [11:0] {
		ST_CLR   = 12'b000000000001,
		ST_IDLE  = 12'b000000000010,
		ST_BDIV  = 12'b000000000100,
		ST_RD    = 12'b000000001000,
		ST_WR    = 12'b000000010000,
		ST_PLOG  = 12'b000000100000,
		ST_RRD   = 12'b000001000000,
		ST_RLOG  = 12'b000010000000,
		ST_RDIV  = 12'b000100000000,
		ST_OUT   = 12'b001000000000,
		ST_WLOG  = 12'b010000000000,
		ST_WDIV  = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [15:0] dmin_q, dmax_q;
	logic [6:0]  nb_q;
	logic [10:0] bw_q;
	logic [COUNT_BITS-1:0] mem [MAX_BINS];
	logic [COUNT_BITS-1:0] rd_q, peak_q;
	logic [BW-1:0] addr_q;
	logic [6:0]    bins_q;
	logic          last_q;
	logic [15:0]   v_q;
	logic [6:0]    j_q;
	logic [lshb_pkg::LOG_W-1:0] lp_q;
	logic [5:0]    row_q;
	logic [10:0]   white_q;
	logic          tl_q;

	logic div_start, div_done, log_start, log_done;
	logic [DW-1:0] div_num, div_den, quo, rem;
	logic [COUNT_BITS-1:0] log_n;
	logic [lshb_pkg::LOG_W-1:0] lg;
	logic [6:0] eb;
	logic [16:0] den17;
	logic [DW-1:0] q_r;
	logic [COUNT_BITS-1:0] inc;
	logic [COUNT_BITS-1:0] peak_nx;

	always_comb begin
		if (nb_q < 7'd2) eb = 7'd2;
		else if (nb_q > 7'(MAX_BINS)) eb = 7'(MAX_BINS);
		else eb = nb_q;
	end

	assign den17 = {1'b0, dmax_q} - {1'b0, dmin_q};

	always_comb begin
		div_num = '0;
		div_den = DW'(1);
		if (state_q == ST_IDLE) begin
			div_num = DW'(({16'd0, 6'(eb - 7'd1)} * (s_axis_tdata - dmin_q)));
			div_den = DW'(den17);
		end else begin
			div_num = DW'(bw_q) * DW'(lg) + DW'(lp_q) - DW'(1);
			div_den = DW'(lp_q);
		end
	end

	assign inc     = (rd_q == CMAX) ? rd_q : rd_q + 1'b1;
	assign peak_nx = (inc > peak_q) ? inc : peak_q;

	assign div_start = (state_q == ST_IDLE && s_axis_tvalid) ||
		(state_q == ST_RLOG && log_done && lp_q != '0);
	assign log_start = (state_q == ST_WR) && last_q || (state_q == ST_RRD);
	assign log_n     = (state_q == ST_WR) ? peak_nx : rd_q;

	lshb_divider u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo, .rem);
	lshb_log2 #(.COUNT_BITS(COUNT_BITS)) u_log (.clk, .arst_n, .start(log_start), .n(log_n),
		.done(log_done), .lg);

	always_comb begin
		q_r = quo;
		if ({rem, 1'b0} > {1'b0, DW'(den17)} ||
			({rem, 1'b0} == {1'b0, DW'(den17)} && quo[0]))
			q_r = quo + DW'(1);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {7'd0, white_q, row_q};
	assign m_axis_tlast  = tl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmin_q <= '0;
			dmax_q <= 16'hFFFF;
			nb_q   <= 7'd64;
			bw_q   <= 11'd256;
		end else if (cfg_valid) begin
			case (lshb_pkg::reg_idx_t'(cfg_index))
				lshb_pkg::REG_DATA_MIN:  dmin_q <= cfg_data;
				lshb_pkg::REG_DATA_MAX:  dmax_q <= cfg_data;
				lshb_pkg::REG_NUM_BINS:  nb_q   <= cfg_data[6:0];
				lshb_pkg::REG_BAR_WIDTH: bw_q   <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			addr_q  <= '0;
			peak_q  <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					addr_q <= addr_q + 1'b1;
					peak_q <= '0;
					if (addr_q == BW'(MAX_BINS - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (s_axis_tvalid) state_q <= ST_BDIV;
				ST_BDIV: if (div_done) begin
					if (dmax_q <= dmin_q || v_q <= dmin_q) addr_q <= '0;
					else if (v_q >= dmax_q || q_r >= DW'(bins_q - 7'd1))
						addr_q <= BW'(bins_q - 7'd1);
					else addr_q <= BW'(q_r);
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					peak_q <= peak_nx;
					state_q <= last_q ? ST_PLOG : ST_IDLE;
				end
				ST_PLOG: if (log_done) begin
					j_q <= '0;
					addr_q <= BW'(bins_q - 7'd1);
					state_q <= ST_WLOG;
				end
				ST_WLOG: state_q <= ST_RRD;
				ST_RRD: state_q <= ST_RLOG;
				ST_RLOG: if (log_done) begin
					if (lp_q == '0) begin
						white_q <= bw_q;
						state_q <= ST_OUT;
					end else state_q <= ST_RDIV;
				end
				ST_RDIV: if (div_done) begin
					white_q <= (quo >= DW'(bw_q)) ? 11'd0 : bw_q - 11'(quo);
					state_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) begin
					if (tl_q) begin
						addr_q <= '0;
						state_q <= ST_CLR;
					end else begin
						j_q <= j_q + 1'b1;
						addr_q <= addr_q - 1'b1;
						state_q <= ST_WLOG;
					end
				end
				ST_WDIV: state_q <= ST_IDLE;
				default: state_q <= ST_CLR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			v_q    <= s_axis_tdata;
			last_q <= s_axis_tlast;
			bins_q <= eb;
		end
		if (state_q == ST_PLOG && log_done) lp_q <= lg;
		row_q <= 6'(j_q);
		tl_q  <= (j_q == bins_q - 7'd1);
		rd_q  <= mem[addr_q];
		if (state_q == ST_CLR) mem[addr_q] <= '0;
		else if (state_q == ST_WR) mem[addr_q] <= inc;
	end
endmodule

[rtl/core/lshb_checker.sv]
`timescale 1ns / 1ps
module lshb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in and out active together");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("payload changed under stall");
	a_row0: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
		else $error("output after last row");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready after accept");
endmodule

bind log_scaled_histogram_bars lshb_checker u_chk (.clk, .arst_n, .s_axis_tvalid,
	.s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast);

[tb/log_scaled_histogram_bars_tb.sv]
`timescale 1ns / 1ps
module log_scaled_histogram_bars_tb;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;
	localparam logic [32:0] COUNT_SAT = 33'h0_FFFF_FFFF;

	typedef struct packed {
		logic [5:0]  row;
		logic [10:0] white;
		logic        last;
	} bar_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	logic [15:0] lo_reg, hi_reg;
	logic [6:0]  bins_reg;
	logic [10:0] width_reg;
	logic [32:0] hist [lshb_pkg::MAX_BINS_DEF];
	logic [32:0] peak;
	bar_row_t    pending_rows[$];

	int gap_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int samples_sent = 0;
	int rows_seen = 0;
	int frames_sent = 0;
	int quiet_cycles = 0;

	log_scaled_histogram_bars uut (.*);

	always #4 clk = ~clk;

	function automatic logic [63:0] fixed_log2(input logic [32:0] n);
		logic [63:0] x, m, lo, hi;
		int e;
		x = {31'd0, n} + 64'd1;
		e = 0;
		for (int i = 0; i < 64; i++)
			if (x[i])
				e = i;
		m = x << (63 - e);
		lo = 64'(lshb_pkg::log_tab({1'b0, m[62:59]}));
		hi = 64'(lshb_pkg::log_tab({1'b0, m[62:59]} + 5'd1));
		return (64'(e) << 16) + lo + (((hi - lo) * {48'd0, m[58:43]}) >> 16);
	endfunction

	function automatic int active_bins();
		if (bins_reg < 2)
			return 2;
		if (bins_reg > lshb_pkg::MAX_BINS_DEF)
			return lshb_pkg::MAX_BINS_DEF;
		return int'(bins_reg);
	endfunction

	function automatic int bin_index(input logic [15:0] v, input int nb);
		logic [31:0] den, num, q, r;
		if (hi_reg <= lo_reg || v <= lo_reg)
			return 0;
		if (v >= hi_reg)
			return nb - 1;
		den = 32'(hi_reg - lo_reg);
		num = 32'(nb - 1) * 32'(v - lo_reg);
		q = num / den;
		r = num % den;
		if (2 * r > den || (2 * r == den && q[0]))
			q++;
		if (q > 32'(nb - 1))
			q = 32'(nb - 1);
		return int'(q);
	endfunction

	task automatic bin_sample(input logic [15:0] v, input logic last);
		int nb, b;
		logic [63:0] lp, num, up, w;
		bar_row_t r;
		nb = active_bins();
		b = bin_index(v, nb);
		if (hist[b] < COUNT_SAT)
			hist[b]++;
		if (hist[b] > peak)
			peak = hist[b];
		if (last) begin
			w = 64'(width_reg);
			lp = fixed_log2(peak);
			for (int j = 0; j < nb; j++) begin
				if (lp == 0) begin
					up = 0;
				end else begin
					num = w * fixed_log2(hist[nb - 1 - j]);
					up = (num + lp - 1) / lp;
				end
				r.row = 6'(j);
				r.white = (up >= w) ? 11'd0 : 11'(w - up);
				r.last = (j == nb - 1);
				pending_rows.push_back(r);
			end
			foreach (hist[i])
				hist[i] = '0;
			peak = '0;
		end
	endtask

	task automatic send_sample(input logic [15:0] v, input logic last);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		bin_sample(v, last);
		samples_sent++;
		if (last)
			frames_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input lshb_pkg::reg_idx_t idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			lshb_pkg::REG_DATA_MIN:  lo_reg = value;
			lshb_pkg::REG_DATA_MAX:  hi_reg = value;
			lshb_pkg::REG_NUM_BINS:  bins_reg = value[6:0];
			lshb_pkg::REG_BAR_WIDTH: width_reg = value[10:0];
			default: ;
		endcase
	endtask

	task automatic setup(input logic [15:0] lo, input logic [15:0] hi, input logic [6:0] nb,
			input logic [10:0] w);
		write_reg(lshb_pkg::REG_DATA_MIN, lo);
		write_reg(lshb_pkg::REG_DATA_MAX, hi);
		write_reg(lshb_pkg::REG_NUM_BINS, {9'd0, nb});
		write_reg(lshb_pkg::REG_BAR_WIDTH, {5'd0, w});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_sample(16'h0000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'h8000, 1'b1);
		drain();
	endtask

	task automatic test_out_of_range();
		setup(16'd1000, 16'd3000, 7'd8, 11'd100);
		send_sample(16'd0, 1'b0);
		send_sample(16'd999, 1'b0);
		send_sample(16'd1000, 1'b0);
		send_sample(16'd3000, 1'b0);
		send_sample(16'hFFFF, 1'b0);
		send_sample(16'd2000, 1'b0);
		send_sample(16'd1125, 1'b1);
		drain();
	endtask

	task automatic test_empty_range();
		setup(16'd500, 16'd500, 7'd4, 11'd1024);
		send_sample(16'd100, 1'b0);
		send_sample(16'd900, 1'b1);
		drain();
		setup(16'hFFFF, 16'd0, 7'd3, 11'd1);
		send_sample(16'h5555, 1'b1);
		drain();
	endtask

	task automatic test_bin_limits();
		setup(16'd0, 16'hFFFF, 7'd0, 11'd2047);
		send_sample(16'hAAAA, 1'b1);
		drain();
		setup(16'd0, 16'hFFFF, 7'd1, 11'd0);
		send_sample(16'hFFFF, 1'b1);
		drain();
		setup(16'd0, 16'd127, 7'd127, 11'd1000);
		send_sample(16'd0, 1'b0);
		send_sample(16'd64, 1'b0);
		send_sample(16'd127, 1'b1);
		drain();
	endtask

	task automatic test_random_frames(input int n_items);
		int left, len;
		left = n_items;
		while (left > 0) begin
			if ($urandom_range(3) == 0)
				setup(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					7'($urandom_range(0, 127)), 11'($urandom_range(0, 2047)));
			else
				setup(16'($urandom_range(0, 2000)), 16'($urandom_range(30000, 65535)),
					7'($urandom_range(2, 16)), 11'($urandom_range(1, 1024)));
			len = $urandom_range(1, 12);
			for (int k = 1; k <= len; k++)
				send_sample(16'($urandom()), k == len);
			left -= len;
			drain();
		end
	endtask

	always @(posedge clk) begin
		bar_row_t got, want;
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.row = m_axis_tdata[5:0];
			got.white = m_axis_tdata[16:6];
			got.last = m_axis_tlast;
			rows_seen++;
			if (pending_rows.size() == 0) begin
				errors++;
				$display("%0t: unexpected row transaction, actual %p", $time, got);
			end else begin
				want = pending_rows.pop_front();
				if (got.row !== want.row)
					$display("%0t: row mismatch, expected %0d actual %0d",
						$time, want.row, got.row);
				if (got.white !== want.white)
					$display("%0t: white_count mismatch, expected %0d actual %0d",
						$time, want.white, got.white);
				if (got.last !== want.last)
					$display("%0t: last_row mismatch, expected %0d actual %0d",
						$time, want.last, got.last);
				if (got !== want)
					errors++;
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("** log_scaled_histogram_bars: FAILED **");
			$finish;
		end
	end

	initial begin
		lo_reg = 16'd0;
		hi_reg = 16'hFFFF;
		bins_reg = 7'd64;
		width_reg = 11'd256;
		foreach (hist[i])
			hist[i] = '0;
		peak = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 11;
		stall_pct = 46;
		test_reset_defaults();
		test_out_of_range();
		test_empty_range();
		test_bin_limits();
		test_random_frames(28);
		gap_pct = 46;
		stall_pct = 11;
		test_random_frames(28);
		gap_pct = 0;
		stall_pct = 0;
		test_random_frames(28);
		if (pending_rows.size() != 0)
			errors++;
		$display("Covered %0d samples in %0d frames, %0d rows checked.",
			samples_sent, frames_sent, rows_seen);
		$display("Settings swept: range edges, empty range, bin and width extremes.");
		if (errors == 0)
			$display("** log_scaled_histogram_bars: PASSED **");
		else
			$display("** log_scaled_histogram_bars: FAILED **");
		$finish;
	end
endmodule
